>>> src/counting_semaphore_fifo_wait_core_defines.svh
// assertion macros shared by the semaphore core
`ifndef COUNTING_SEMAPHORE_FIFO_WAIT_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAIT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSFW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/csfw_pkg.sv
// types and constants of the counting semaphore core
package csfw_pkg;

    localparam int unsigned THREAD_W  = 8;
    localparam int unsigned PERMIT_W  = 16;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [REQ_W-1:0] REQ_ACQUIRE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WAKE     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FAIR_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PERMITS  = 1'b1;

    localparam logic [PERMIT_W-1:0] INIT_PERMITS_RESET = 16'd1;
    localparam logic [PERMIT_W-1:0] COUNT_MAX          = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_WAITING  = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NOT_HEAD = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        OP_ACQUIRE,
        OP_RELEASE,
        OP_WAKE,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [THREAD_W-1:0] thread_id;
        logic [PERMIT_W-1:0] permit_amount;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [PERMIT_W-1:0] permits_left;
    } t_res;

    typedef struct packed {
        t_op                 op;
        logic [THREAD_W-1:0] thread_id;
        logic [PERMIT_W-1:0] permit_amount;
    } t_cmd;

    typedef struct packed {
        logic [THREAD_W-1:0] thread_id;
        logic [PERMIT_W-1:0] permits;
    } t_wait_entry;

endpackage

>>> src/csfw_front.sv
// front end: accepts requests, decodes them and queues commands for the back end
module csfw_front
    import csfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    t_cmd              w_dec;
    logic              w_wr_en;
    logic              w_rd_en;

    always_comb begin
        w_dec.thread_id     = i_req.thread_id;
        w_dec.permit_amount = i_req.permit_amount;
        unique case (i_req.req_type)
            REQ_ACQUIRE:  w_dec.op = OP_ACQUIRE;
            REQ_RELEASE:  w_dec.op = OP_RELEASE;
            REQ_WAKE:     w_dec.op = OP_WAKE;
            REQ_RESERVED: w_dec.op = OP_NONE;
            default:      w_dec.op = OP_NONE;
        endcase
    end

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_wr_en     = i_push && !o_full;
    assign w_rd_en     = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_rd_en && !w_wr_en) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr_en) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_q[r_wr] <= w_dec;
        end
    end

endmodule

>>> src/csfw_result_q.sv
// result queue: holds finished results until the receiver pops them
module csfw_result_q
    import csfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    t_res              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              w_wr_en;
    logic              w_rd_en;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_rd_en && !w_wr_en) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr_en) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

>>> src/csfw_back.sv
// back end: permit counter, wait and holder queues, request execution
module csfw_back
    import csfw_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH   = 16,
    parameter int unsigned HOLDER_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [PERMIT_W-1:0]  i_cfg_wdata,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output t_res                 o_res
);

    localparam int unsigned WIW = $clog2(WAIT_DEPTH);
    localparam int unsigned WFW = $clog2(WAIT_DEPTH + 1);
    localparam int unsigned HIW = $clog2(HOLDER_DEPTH);
    localparam int unsigned HFW = $clog2(HOLDER_DEPTH + 1);

    t_back_state r_state;
    t_back_state n_state;

    t_cmd                r_cmd;
    logic                r_fair;
    logic [PERMIT_W-1:0] r_count;
    logic [PERMIT_W-1:0] n_count;

    t_wait_entry         r_wait_mem [WAIT_DEPTH];
    t_wait_entry         r_wait_rd;
    logic [WIW-1:0]      r_wait_head;
    logic [WIW-1:0]      r_wait_tail;
    logic [WFW-1:0]      r_wait_fill;

    logic [THREAD_W-1:0] r_hold_mem [HOLDER_DEPTH];
    logic [THREAD_W-1:0] r_hold_rd;
    logic [HIW-1:0]      r_hold_head;
    logic [HIW-1:0]      r_hold_tail;
    logic [HFW-1:0]      r_hold_fill;

    logic              w_exec;
    logic              w_wait_push;
    logic              w_wait_pop;
    logic              w_hold_push;
    logic              w_hold_pop;
    logic              w_wait_empty;
    logic              w_wait_full;
    logic              w_hold_empty;
    logic              w_hold_full;
    logic [PERMIT_W:0] w_sum;
    t_status           w_status;

    assign w_wait_empty = (r_wait_fill == '0);
    assign w_wait_full  = (r_wait_fill == WFW'(WAIT_DEPTH));
    assign w_hold_empty = (r_hold_fill == '0);
    assign w_hold_full  = (r_hold_fill == HFW'(HOLDER_DEPTH));
    assign w_sum        = {1'b0, r_count} + {1'b0, r_cmd.permit_amount};

    // sequencer: fetch a command, read queue heads, then execute
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) n_state = BK_READ;
            end
            BK_READ: begin
                n_state = BK_EXEC;
            end
            BK_EXEC: begin
                if (!i_res_full) n_state = i_cmd_valid ? BK_READ : BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        w_exec    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            BK_READ: begin
                o_cmd_pop = 1'b0;
            end
            BK_EXEC: begin
                w_exec    = !i_res_full;
                o_cmd_pop = !i_res_full && i_cmd_valid;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    // request decision on the registered queue heads
    always_comb begin
        w_status    = ST_WAITING;
        n_count     = r_count;
        w_wait_push = 1'b0;
        w_wait_pop  = 1'b0;
        w_hold_push = 1'b0;
        w_hold_pop  = 1'b0;
        unique case (r_cmd.op)
            OP_ACQUIRE: begin
                if (r_count >= r_cmd.permit_amount && w_wait_empty) begin
                    if (r_fair && w_hold_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_hold_push = r_fair;
                        n_count     = r_count - r_cmd.permit_amount;
                        w_status    = ST_GRANTED;
                    end
                end else if (w_wait_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_wait_push = 1'b1;
                    w_status    = ST_QUEUED;
                end
            end
            OP_RELEASE: begin
                if (r_fair && (w_hold_empty || r_hold_rd != r_cmd.thread_id)) begin
                    w_status = ST_NOT_HEAD;
                end else begin
                    w_hold_pop = r_fair;
                    n_count    = w_sum[PERMIT_W] ? COUNT_MAX : w_sum[PERMIT_W-1:0];
                    w_status   = ST_RELEASED;
                end
            end
            OP_WAKE: begin
                if (w_wait_empty || r_wait_rd.thread_id != r_cmd.thread_id
                        || r_count < r_wait_rd.permits) begin
                    w_status = ST_WAITING;
                end else if (r_fair && w_hold_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_hold_push = r_fair;
                    w_wait_pop  = 1'b1;
                    n_count     = r_count - r_wait_rd.permits;
                    w_status    = ST_WOKEN;
                end
            end
            OP_NONE: begin
                w_status = ST_WAITING;
            end
            default: begin
                w_status = ST_WAITING;
            end
        endcase
    end

    assign o_res_push        = w_exec;
    assign o_res.status      = w_status;
    assign o_res.permits_left = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // the user must make config writes only while no transaction is in flight; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fair  <= 1'b0;
            r_count <= INIT_PERMITS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_FAIR_MODE) begin
                r_fair <= i_cfg_wdata[0];
            end else begin
                r_count <= i_cfg_wdata;
            end
        end else if (w_exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_head <= '0;
            r_wait_tail <= '0;
            r_wait_fill <= '0;
            r_hold_head <= '0;
            r_hold_tail <= '0;
            r_hold_fill <= '0;
        end else if (w_exec) begin
            if (w_wait_push) begin
                r_wait_tail <= (r_wait_tail == WIW'(WAIT_DEPTH - 1)) ? '0
                                                                     : r_wait_tail + WIW'(1);
                r_wait_fill <= r_wait_fill + WFW'(1);
            end else if (w_wait_pop) begin
                r_wait_head <= (r_wait_head == WIW'(WAIT_DEPTH - 1)) ? '0
                                                                     : r_wait_head + WIW'(1);
                r_wait_fill <= r_wait_fill - WFW'(1);
            end
            if (w_hold_push) begin
                r_hold_tail <= (r_hold_tail == HIW'(HOLDER_DEPTH - 1)) ? '0
                                                                       : r_hold_tail + HIW'(1);
                r_hold_fill <= r_hold_fill + HFW'(1);
            end else if (w_hold_pop) begin
                r_hold_head <= (r_hold_head == HIW'(HOLDER_DEPTH - 1)) ? '0
                                                                       : r_hold_head + HIW'(1);
                r_hold_fill <= r_hold_fill - HFW'(1);
            end
        end
    end

    // head reads are registered; the read stage sees all earlier writes
    always_ff @(posedge i_clk) begin
        if (w_exec && w_wait_push) begin
            r_wait_mem[r_wait_tail] <= '{thread_id: r_cmd.thread_id,
                                         permits: r_cmd.permit_amount};
        end
        r_wait_rd <= r_wait_mem[r_wait_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_hold_push) begin
            r_hold_mem[r_hold_tail] <= r_cmd.thread_id;
        end
        r_hold_rd <= r_hold_mem[r_hold_head];
    end

endmodule

>>> src/counting_semaphore_fifo_wait_core.sv
// Counting semaphore with a FIFO wait queue and an optional holder queue.
// Requests (acquire, release, wake poll) enter through a queue port: a
// transaction is taken when push is high and full is low. Each request gives
// exactly one result (status and permits left), read from a queue port: the
// oldest result is shown while empty is low and leaves when pop is high.
// Configuration is a plain write port (fair mode, initial permits); writing
// the initial permits reloads the counter. Write only while the block idles.
// A request goes through a two-entry command queue, then the back end reads
// the wait and holder queue heads out of memory in its read state and
// decides and updates in its execute state. The head read of the queue
// memories is registered, so each request passes the read state; the next
// request is taken from the command queue while the current one executes.
// When the receiver stops popping, the two-entry result queue fills, the
// back end holds its current request, and the command queue then fills and
// raises full. Synchronous reset empties all queues, clears fair mode and
// sets the permit count to one.
`include "counting_semaphore_fifo_wait_core_defines.svh"

module counting_semaphore_fifo_wait_core
    import csfw_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH   = 16,
    parameter int unsigned HOLDER_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  t_req                 i_req,
    output logic                 full,
    output logic                 empty,
    output t_res                 o_res,
    input  logic                 pop,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [PERMIT_W-1:0]  i_cfg_wdata
);

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;
    logic w_res_full;
    logic w_res_push;
    t_res w_res;

    csfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    csfw_back #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .HOLDER_DEPTH (HOLDER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    csfw_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (o_res),
        .i_pop   (pop)
    );

    `CSFW_ASSERT_IMPLY(a_cmd_pop_valid, i_clk, i_rst_n, w_cmd_pop, w_cmd_valid, "command popped from empty queue")
    `CSFW_ASSERT_IMPLY(a_res_push_room, i_clk, i_rst_n, w_res_push, !w_res_full, "result pushed into full queue")
    `CSFW_ASSERT_NEXT(a_res_visible, i_clk, i_rst_n, w_res_push, !empty, "pushed result not visible")
    `CSFW_ASSERT_NEXT(a_fetch_no_result, i_clk, i_rst_n, w_cmd_pop, !w_res_push, "result in head read cycle")

endmodule

>>> tb/sv/csfw_result_checker.sv
// checker: mirrors the semaphore state, predicts each result and compares it
module csfw_result_checker
    import csfw_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH   = 16,
    parameter int unsigned HOLDER_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_req                 i_req,
    input  logic                 i_pop,
    input  logic                 i_empty,
    input  t_res                 i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [PERMIT_W-1:0]  i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic                fair_en;
    logic [PERMIT_W-1:0] init_permits;
    logic [PERMIT_W-1:0] permit_count;

    logic [THREAD_W-1:0] wait_tid [WAIT_DEPTH];
    logic [PERMIT_W-1:0] wait_amt [WAIT_DEPTH];
    int unsigned         wait_head;
    int unsigned         wait_fill;

    logic [THREAD_W-1:0] holder_tid [HOLDER_DEPTH];
    logic [PERMIT_W-1:0] holder_amt [HOLDER_DEPTH];
    int unsigned         holder_head;
    int unsigned         holder_fill;

    t_res pending_results [$];
    int   fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void holder_push(input logic [THREAD_W-1:0] tid,
                                        input logic [PERMIT_W-1:0] amt);
        int unsigned slot;
        slot = (holder_head + holder_fill) % HOLDER_DEPTH;
        holder_tid[slot] = tid;
        holder_amt[slot] = amt;
        holder_fill++;
    endfunction

    // applies one request to the mirrored state and returns its result
    function automatic t_res semaphore_outcome(input t_req r);
        t_res                res;
        t_status             st;
        int unsigned         slot;
        logic [PERMIT_W-1:0] need;
        logic [PERMIT_W:0]   sum;
        case (r.req_type)
            REQ_ACQUIRE: begin
                if (permit_count >= r.permit_amount && wait_fill == 0) begin
                    if (fair_en && holder_fill >= HOLDER_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        if (fair_en) holder_push(r.thread_id, r.permit_amount);
                        permit_count = permit_count - r.permit_amount;
                        st = ST_GRANTED;
                    end
                end else if (wait_fill >= WAIT_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    slot = (wait_head + wait_fill) % WAIT_DEPTH;
                    wait_tid[slot] = r.thread_id;
                    wait_amt[slot] = r.permit_amount;
                    wait_fill++;
                    st = ST_QUEUED;
                end
            end
            REQ_RELEASE: begin
                if (fair_en && (holder_fill == 0 || holder_tid[holder_head] != r.thread_id)) begin
                    st = ST_NOT_HEAD;
                end else begin
                    if (fair_en) begin
                        holder_head = (holder_head + 1) % HOLDER_DEPTH;
                        holder_fill--;
                    end
                    sum = {1'b0, permit_count} + {1'b0, r.permit_amount};
                    permit_count = sum > {1'b0, COUNT_MAX} ? COUNT_MAX : sum[PERMIT_W-1:0];
                    st = ST_RELEASED;
                end
            end
            REQ_WAKE: begin
                if (wait_fill == 0 || wait_tid[wait_head] != r.thread_id) begin
                    st = ST_WAITING;
                end else begin
                    need = wait_amt[wait_head];
                    if (permit_count < need) begin
                        st = ST_WAITING;
                    end else if (fair_en && holder_fill >= HOLDER_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        if (fair_en) holder_push(r.thread_id, need);
                        permit_count = permit_count - need;
                        wait_head = (wait_head + 1) % WAIT_DEPTH;
                        wait_fill--;
                        st = ST_WOKEN;
                    end
                end
            end
            default: begin
                st = ST_WAITING;
            end
        endcase
        res.status       = st;
        res.permits_left = permit_count;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            fair_en      = 1'b0;
            init_permits = INIT_PERMITS_RESET;
            permit_count = INIT_PERMITS_RESET;
            wait_head    = 0;
            wait_fill    = 0;
            holder_head  = 0;
            holder_fill  = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_FAIR_MODE) begin
                    fair_en = i_cfg_wdata[0];
                end else if (i_cfg_addr == CFG_INIT_PERMITS) begin
                    init_permits = i_cfg_wdata;
                    permit_count = i_cfg_wdata;
                end
            end
            if (i_push && !i_full) begin
                pending_results.push_back(semaphore_outcome(i_req));
            end
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d permits_left %0d",
                           i_res.status, i_res.permits_left);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status mismatch: expected %0d actual %0d",
                               want.status, i_res.status);
                        fail_count++;
                    end
                    if (i_res.permits_left !== want.permits_left) begin
                        $error("permits_left mismatch: expected %0d actual %0d",
                               want.permits_left, i_res.permits_left);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> tb/sv/tb_counting_semaphore_fifo_wait_core.sv
// testbench top: clock, reset, request stimulus, result draining and verdict
module tb_counting_semaphore_fifo_wait_core;
    import csfw_pkg::*;

    localparam int unsigned WAIT_DEPTH     = 16;
    localparam int unsigned HOLDER_DEPTH   = 16;
    localparam int          STALL_LIMIT    = 5000;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          POOL_SIZE      = 4;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    t_req                 i_req       = '0;
    logic                 full;
    logic                 empty;
    t_res                 o_res;
    logic                 pop         = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [PERMIT_W-1:0]  i_cfg_wdata = '0;

    int    fail_count;
    int    pending;
    t_idle idle_mode     = IDLE_NONE;
    int    hold_requests = 0;
    int    holds_done    = 0;
    int    hold_left     = 0;
    int    stall_cycles  = 0;

    logic [THREAD_W-1:0] thread_pool [POOL_SIZE];
    logic [THREAD_W-1:0] issued_threads [$];

    counting_semaphore_fifo_wait_core #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .HOLDER_DEPTH (HOLDER_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .empty       (empty),
        .o_res       (o_res),
        .pop         (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    csfw_result_checker #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .HOLDER_DEPTH (HOLDER_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req        (i_req),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 57;
            IDLE_BOTH: return $urandom_range(0, 99) < 32;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 57;
            IDLE_BOTH: return $urandom_range(0, 99) < 32;
            default:   return 1'b0;
        endcase
    endfunction

    // result side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            pop        <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            pop <= !receiver_stalls();
        end
    end

    // no transaction on either side for too long ends the run
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("counting_semaphore_fifo_wait_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_req make_req(input logic [REQ_W-1:0] kind,
                                      input logic [THREAD_W-1:0] tid,
                                      input logic [PERMIT_W-1:0] amt);
        t_req r;
        r.req_type      = kind;
        r.thread_id     = tid;
        r.permit_amount = amt;
        return r;
    endfunction

    function automatic logic [THREAD_W-1:0] pick_thread();
        if ($urandom_range(0, 99) < 90) return thread_pool[$urandom_range(0, POOL_SIZE-1)];
        return THREAD_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PERMIT_W-1:0] random_amount();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return PERMIT_W'($urandom_range(0, 8));
        if (roll < 85) return PERMIT_W'($urandom_range(0, 65535));
        if (roll < 93) return COUNT_MAX;
        return '0;
    endfunction

    // releases and polls mostly follow the order in which acquires went out
    function automatic t_req random_req();
        int                  roll;
        logic [THREAD_W-1:0] tid;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            tid = pick_thread();
            issued_threads.push_back(tid);
            if (issued_threads.size() > 32) void'(issued_threads.pop_front());
            return make_req(REQ_ACQUIRE, tid, random_amount());
        end
        if (roll < 65) begin
            if (issued_threads.size() > 0 && $urandom_range(0, 99) < 60)
                tid = issued_threads.pop_front();
            else
                tid = pick_thread();
            return make_req(REQ_RELEASE, tid, random_amount());
        end
        if (roll < 95) begin
            if (issued_threads.size() > 0 && $urandom_range(0, 99) < 60)
                tid = issued_threads[0];
            else
                tid = pick_thread();
            return make_req(REQ_WAKE, tid, random_amount());
        end
        return make_req(REQ_RESERVED, pick_thread(), random_amount());
    endfunction

    task automatic send_item(input t_req r);
        while (sender_waits()) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic fair, input logic [PERMIT_W-1:0] init);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FAIR_MODE;
        i_cfg_wdata <= {{(PERMIT_W-1){1'b0}}, fair};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_INIT_PERMITS;
        i_cfg_wdata <= init;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic fair, input logic [PERMIT_W-1:0] init,
                             input t_idle mode, input int n_items, input bit with_hold);
        int  sent;
        int  burst_left;
        bit  burst_zero;
        wait_idle();
        idle_mode = mode;
        configure(fair, init);
        foreach (thread_pool[k]) thread_pool[k] = THREAD_W'($urandom_range(0, 255));
        issued_threads.delete();
        burst_left = 0;
        burst_zero = 1'b0;
        for (sent = 0; sent < n_items; sent++) begin
            if (with_hold && sent == n_items / 3) hold_requests++;
            if (burst_left == 0 && $urandom_range(0, 99) < 2) begin
                burst_left = WAIT_DEPTH + 1;
                burst_zero = $urandom_range(0, 1);
            end
            if (burst_left > 0) begin
                // consecutive acquires to run the wait or holder queue full
                burst_left--;
                send_item(make_req(REQ_ACQUIRE, pick_thread(),
                          burst_zero ? '0 : PERMIT_W'($urandom_range(16'h8000, 16'hFFFF))));
            end else begin
                send_item(random_req());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // non-fair: grant, queue, each poll outcome, saturation, unused type
        configure(1'b0, 16'd3);
        send_item(make_req(REQ_ACQUIRE,  8'h00, 16'h0000));
        send_item(make_req(REQ_ACQUIRE,  8'hFF, 16'hFFFF));
        send_item(make_req(REQ_WAKE,     8'h00, 16'h0000));
        send_item(make_req(REQ_WAKE,     8'hFF, 16'hFFFF));
        send_item(make_req(REQ_RELEASE,  8'h12, 16'hFFFF));
        send_item(make_req(REQ_WAKE,     8'hFF, 16'h0000));
        send_item(make_req(REQ_WAKE,     8'hFF, 16'h0000));
        send_item(make_req(REQ_RESERVED, 8'hAA, 16'h5555));
        send_item(make_req(REQ_RELEASE,  8'h55, 16'hFFFF));
        send_item(make_req(REQ_RELEASE,  8'h01, 16'h0001));

        // fair: releases must follow grant order
        wait_idle();
        configure(1'b1, 16'd2);
        send_item(make_req(REQ_ACQUIRE, 8'h05, 16'd1));
        send_item(make_req(REQ_ACQUIRE, 8'h06, 16'd1));
        send_item(make_req(REQ_ACQUIRE, 8'h07, 16'd1));
        send_item(make_req(REQ_RELEASE, 8'h06, 16'd1));
        send_item(make_req(REQ_RELEASE, 8'h05, 16'd1));
        send_item(make_req(REQ_WAKE,    8'h07, 16'hAAAA));
        send_item(make_req(REQ_RELEASE, 8'h06, 16'd1));
        send_item(make_req(REQ_RELEASE, 8'h07, 16'hFFFF));
        send_item(make_req(REQ_RELEASE, 8'h09, 16'd1));

        run_phase(1'b0, 16'h0000, IDLE_NONE, 55, 1'b0);
        run_phase(1'b1, 16'hFFFF, IDLE_SEND, 55, 1'b0);
        run_phase(1'b1, 16'd4,    IDLE_RECV, 55, 1'b0);
        run_phase(1'b0, 16'd16,   IDLE_BOTH, 55, 1'b1);
        run_phase(1'b1, 16'd1,    IDLE_NONE, 55, 1'b1);
        run_phase(1'b0, 16'hFFFF, IDLE_BOTH, 55, 1'b0);
        run_phase(1'b1, 16'd40,   IDLE_SEND, 60, 1'b0);
        run_phase(1'b1, 16'h0000, IDLE_RECV, 60, 1'b0);

        wait_idle();
        if (fail_count == 0) begin
            $display("counting_semaphore_fifo_wait_core regression: pass");
        end else begin
            $display("counting_semaphore_fifo_wait_core regression: fail");
        end
        $finish;
    end

endmodule

>>> counting_semaphore_fifo_wait_core.f
+incdir+src
src/csfw_pkg.sv
src/csfw_front.sv
src/csfw_result_q.sv
src/csfw_back.sv
src/counting_semaphore_fifo_wait_core.sv
tb/sv/csfw_result_checker.sv
tb/sv/tb_counting_semaphore_fifo_wait_core.sv
